// ===== rtl/core/u8esc_pkg.sv =====
// u8esc_pkg: shared types, microcode rom and byte classification helpers
// for the utf-8 stream escaper; no dependencies
package u8esc_pkg;

    localparam int StepW = 3;
    typedef logic [StepW-1:0] step_t;

    // program addresses
    localparam step_t ST_IDLE    = 3'd0;
    localparam step_t ST_DECODE  = 3'd1;
    localparam step_t ST_ESC_BSL = 3'd2;
    localparam step_t ST_ESC_X   = 3'd3;
    localparam step_t ST_ESC_HI  = 3'd4;
    localparam step_t ST_ESC_LO  = 3'd5;
    localparam step_t ST_COPY    = 3'd6;

    localparam logic [7:0] CHAR_BSL = 8'h5C;
    localparam logic [7:0] CHAR_X   = 8'h78;

    typedef enum logic [2:0] {
        CH_NONE,
        CH_BSL,
        CH_X,
        CH_HI,
        CH_LO,
        CH_BUF
    } char_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ACCEPT,
        JMP_DISPATCH,
        JMP_COPY
    } jmp_t;

    typedef struct packed {
        logic      ready;    // take an input word in this step
        logic      consume;  // drop the front byte after this step
        char_sel_t sel;      // character emitted, none for control steps
        jmp_t      jmp;      // how the next step is chosen
        step_t     target;   // jump target
    } uop_t;

    function automatic uop_t ucode(step_t s);
        uop_t u;
        u = '{ready: 1'b0, consume: 1'b0, sel: CH_NONE, jmp: JMP_NEXT, target: ST_IDLE};
        unique case (s)
            ST_IDLE:    u = '{1'b1, 1'b0, CH_NONE, JMP_ACCEPT,   ST_DECODE};
            ST_DECODE:  u = '{1'b0, 1'b0, CH_NONE, JMP_DISPATCH, ST_IDLE};
            ST_ESC_BSL: u = '{1'b0, 1'b0, CH_BSL,  JMP_NEXT,     ST_ESC_X};
            ST_ESC_X:   u = '{1'b0, 1'b0, CH_X,    JMP_NEXT,     ST_ESC_HI};
            ST_ESC_HI:  u = '{1'b0, 1'b0, CH_HI,   JMP_NEXT,     ST_ESC_LO};
            ST_ESC_LO:  u = '{1'b0, 1'b1, CH_LO,   JMP_NEXT,     ST_DECODE};
            ST_COPY:    u = '{1'b0, 1'b1, CH_BUF,  JMP_COPY,     ST_DECODE};
            default:    u = '{1'b0, 1'b0, CH_NONE, JMP_NEXT,     ST_IDLE};
        endcase
        return u;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
            c = {4'h3, v};
        else
            c = 8'h37 + {4'h0, v};
        return c;
    endfunction

    // sequence length from the lead byte, zero for an invalid lead
    function automatic logic [2:0] seq_len(logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)
            len = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

// ===== rtl/core/utf8_stream_escaper_top.sv =====
// utf8_stream_escaper_top: byte-serial utf-8 aware escaper run by a small
// microcode program; depends on u8esc_pkg
//
// channel  dir  handshake             payload
// s_       in   s_tvalid / s_tready   s_tdata = in_byte, s_tuser = byte_present, flush
// m_       out  m_tvalid / m_tready   m_tdata = out_char, m_tlast = last
//
// one program step per cycle unless an output stall holds it: a word takes an idle
// step that accepts it and a decode step, then every token takes one emitting step
// per character (escape = 4, raw sequence = its byte count) plus one more decode step
// output stalls freeze the step counter on the emitting step
// reset clears the step counter, byte count and output valid; held bytes
// are kept only as far as the count says
module utf8_stream_escaper_top
    import u8esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [0] byte_present, [1] flush
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    // sequencer state
    step_t      step_reg, step_next;
    logic [1:0] cnt_reg, cnt_next;      // raw bytes left to copy, minus one
    logic [2:0] n_reg, n_next;          // bytes in the working buffer
    logic       fin_reg, fin_next;      // current word carries a flush

    // working buffer, front byte is always the one under decode
    logic [7:0] buf_reg [4];
    logic [7:0] buf_next [4];

    // output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    uop_t       uop;
    logic       emit;
    logic       fire;
    logic       accept;

    // front token decode
    logic [2:0] len0;
    logic [2:0] len1;
    logic [2:0] n_less;
    logic       printable;
    logic       seq_good;
    logic       tok_hold;
    logic       tok_copy;
    logic       last_after;
    logic       final_char;
    logic [7:0] char_val;

    assign uop    = ucode(step_reg);
    assign emit   = uop.sel != CH_NONE;
    // emitting steps wait for room in the output register
    assign fire   = !emit || !m_tvalid_reg || m_tready;
    assign accept = s_tvalid && uop.ready;

    assign len0   = seq_len(buf_reg[0]);
    assign len1   = seq_len(buf_reg[1]);
    assign n_less = n_reg - 3'd1;

    assign printable = (buf_reg[0] >= 8'h20 && buf_reg[0] != 8'h7F)
                       || buf_reg[0] == 8'h0A || buf_reg[0] == 8'h09;

    always_comb
    begin
        unique case (len0)
            3'd2:
                seq_good = is_cont(buf_reg[1]);
            3'd3:
                seq_good = is_cont(buf_reg[1]) && is_cont(buf_reg[2])
                           && !(buf_reg[0] == 8'hE0 && buf_reg[1] < 8'hA0)
                           && !(buf_reg[0] == 8'hED && buf_reg[1] >= 8'hA0);
            3'd4:
                seq_good = is_cont(buf_reg[1]) && is_cont(buf_reg[2])
                           && is_cont(buf_reg[3])
                           && !(buf_reg[0] == 8'hF0 && buf_reg[1] < 8'h90)
                           && !(buf_reg[0] == 8'hF4 && buf_reg[1] >= 8'h90);
            default:
                seq_good = 1'b0;
        endcase
    end

    // incomplete multi-byte sequence waits for more input unless flushed
    assign tok_hold = !fin_reg && len0 >= 3'd2 && len0 > n_reg;
    assign tok_copy = (len0 == 3'd1) ? printable
                                     : (len0 >= 3'd2 && len0 <= n_reg && seq_good);

    // once the front byte is consumed, nothing more comes out if the rest
    // is empty or is an incomplete sequence that stays held
    assign last_after = (n_less == 3'd0)
                        || (!fin_reg && len1 >= 3'd2 && len1 > n_less);
    assign final_char = uop.consume && (uop.jmp != JMP_COPY || cnt_reg == 2'd0);

    always_comb
    begin
        unique case (uop.sel)
            CH_BSL:  char_val = CHAR_BSL;
            CH_X:    char_val = CHAR_X;
            CH_HI:   char_val = hex_char(buf_reg[0][7:4]);
            CH_LO:   char_val = hex_char(buf_reg[0][3:0]);
            CH_BUF:  char_val = buf_reg[0];
            default: char_val = buf_reg[0];
        endcase
    end

    always_comb
    begin
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        fin_next      = fin_reg;
        buf_next      = buf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tready)
            m_tvalid_next = 1'b0;

        if (accept)
        begin
            fin_next = s_tuser[1];
            if (s_tuser[0])
            begin
                buf_next[n_reg[1:0]] = s_tdata;
                n_next               = n_reg + 3'd1;
            end
        end

        if (fire)
        begin
            if (emit)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = char_val;
                m_tlast_next  = final_char && last_after;
            end
            if (uop.consume)
            begin
                buf_next[0] = buf_reg[1];
                buf_next[1] = buf_reg[2];
                buf_next[2] = buf_reg[3];
                n_next      = n_less;
            end
            unique case (uop.jmp)
                JMP_NEXT:
                    step_next = uop.target;
                JMP_ACCEPT:
                    if (accept)
                        step_next = uop.target;
                JMP_DISPATCH:
                    priority if (n_reg == 3'd0 || tok_hold)
                        step_next = ST_IDLE;
                    else if (tok_copy)
                    begin
                        step_next = ST_COPY;
                        cnt_next  = 2'(len0 - 3'd1);
                    end
                    else
                        step_next = ST_ESC_BSL;
                JMP_COPY:
                    if (cnt_reg == 2'd0)
                        step_next = uop.target;
                    else
                        cnt_next = cnt_reg - 2'd1;
                default:
                    step_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_IDLE;
            cnt_reg      <= 2'd0;
            n_reg        <= 3'd0;
            fin_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 8'h00;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            fin_reg      <= fin_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // buffer content is meaningful only below the byte count
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign s_tready = uop.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/core/u8esc_checker.sv =====
// u8esc_checker: port-level assertions for the utf-8 stream escaper
// bound to utf8_stream_escaper_top; no package dependencies
module u8esc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a new input word is never taken while its predecessor is mid-output
    a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while earlier word still emitting");

    // an accepted word is decoded before the next one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // no raw control byte other than lf and tab ever leaves the block
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= 8'h20 || m_tdata == 8'h0A || m_tdata == 8'h09)
                     && m_tdata != 8'h7F)
        else $error("unescaped control character on output");

endmodule

bind utf8_stream_escaper_top u8esc_checker u_u8esc_checker (.*);

// ===== verif/utf8_stream_escaper_top_tb.sv =====
// utf8_stream_escaper_top_tb: self-checking testbench for the utf-8 stream escaper
// holds its own escaper predictor in a small scoreboard class
// needs only the rtl (utf8_stream_escaper_top and u8esc_pkg)
`timescale 1ns / 100ps

// expected characters of every accepted word, checked in order
class escape_scoreboard;

    // character codes the escaper treats specially
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DEL        = 8'h7F;
    localparam logic [7:0] ESC_BACKSLASH = 8'h5C;
    localparam logic [7:0] ESC_X         = 8'h78;

    logic [7:0]  carry_bytes [3];      // incomplete sequence kept between words
    int unsigned carry_count;
    logic [7:0]  seq_buf [4];          // carried bytes plus the new byte
    logic [7:0]  word_chars [$];       // characters of the word being predicted
    logic [8:0]  expected_chars [$];   // {last, char}, oldest first
    int unsigned mismatches;

    function new();
        carry_count = 0;
        mismatches  = 0;
    endfunction

    // bytes a sequence should have, judged by its lead; zero for a bad lead
    function int lead_length(logic [7:0] b);
        if (b < 8'h80)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // continuation bytes present, no overlong, no surrogate, nothing past U+10FFFF
    function bit seq_well_formed(int start, int len);
        logic [7:0] lead;
        logic [7:0] second;
        int i;
        lead   = seq_buf[start];
        second = seq_buf[start + 1];
        for (i = 1; i < len; i++)
            if (seq_buf[start + i][7:6] != 2'b10)
                return 1'b0;
        if (len == 3 && ((lead == 8'hE0 && second < 8'hA0) ||
                         (lead == 8'hED && second >= 8'hA0)))
            return 1'b0;
        if (len == 4 && ((lead == 8'hF0 && second < 8'h90) ||
                         (lead == 8'hF4 && second >= 8'h90)))
            return 1'b0;
        return 1'b1;
    endfunction

    function logic [7:0] hex_digit(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        return 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    function void add_char(logic [7:0] c);
        word_chars = {word_chars, c};
    endfunction

    function void push_escape(logic [7:0] b);
        add_char(ESC_BACKSLASH);
        add_char(ESC_X);
        add_char(hex_digit(b[7:4]));
        add_char(hex_digit(b[3:0]));
    endfunction

    // escaped output of one accepted input word
    function void add_escaped_chars(logic [7:0] b, bit present, bit fl);
        int n;
        int pos;
        int len;
        int i;
        logic [7:0] c;
        bit tail;
        logic [8:0] entry;
        n = 0;
        pos = 0;
        word_chars.delete();
        for (i = 0; i < carry_count; i++)
        begin
            seq_buf[n] = carry_bytes[i];
            n++;
        end
        if (present)
        begin
            seq_buf[n] = b;
            n++;
        end
        while (pos < n)
        begin
            c = seq_buf[pos];
            len = lead_length(c);
            if (len == 1)
            begin
                if ((c < CH_SPACE && c != CH_LF && c != CH_TAB) || c == CH_DEL)
                    push_escape(c);
                else
                    add_char(c);
                pos++;
            end
            else if (len != 0 && pos + len <= n && seq_well_formed(pos, len))
            begin
                for (i = 0; i < len; i++)
                    add_char(seq_buf[pos + i]);
                pos += len;
            end
            else if (!fl && len != 0 && pos + len > n)
            begin
                // wait for the rest of the sequence
                break;
            end
            else
            begin
                // bad lead, stray continuation, failed check or flushed remainder
                push_escape(c);
                pos++;
            end
        end
        carry_count = n - pos;
        for (i = 0; i < carry_count; i++)
            carry_bytes[i] = seq_buf[pos + i];
        foreach (word_chars[k])
        begin
            tail = (k == word_chars.size() - 1);
            entry = {tail, word_chars[k]};
            expected_chars = {expected_chars, entry};
        end
    endfunction

    function void check_char(logic [7:0] c, logic l);
        logic [8:0] want;
        if (expected_chars.size() == 0)
        begin
            $error("out_char %h arrived with nothing expected", c);
            mismatches++;
            return;
        end
        want = expected_chars.pop_front();
        if (c !== want[7:0])
        begin
            $error("out_char mismatch: expected %h, got %h", want[7:0], c);
            mismatches++;
        end
        if (l !== want[8])
        begin
            $error("last mismatch: expected %b, got %b", want[8], l);
            mismatches++;
        end
    endfunction

endclass

module utf8_stream_escaper_top_tb;

    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off to back up the block
    localparam int DRAIN_CYCLES = 40;      // quiet time after the last expected word
    localparam int CYCLE_LIMIT  = 500000;  // far above the slowest legal run

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic [1:0] s_tuser;    // [0] byte_present, [1] flush
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_char
    logic       m_tlast;

    escape_scoreboard sb;

    // knobs shared by the stimulus, the receiver and the main sequence
    bit          send_idle;
    bit          recv_idle;
    bit          hold_pending;
    int unsigned items_sent;
    int unsigned cycles = 0;

    utf8_stream_escaper_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog, so a hung block still ends the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte(int lo, int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // offer one word, entered and left at a falling edge; the prediction is
    // made at the rising edge that accepts it
    task automatic send_word(input logic [7:0] b, input bit present, input bit fl);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = {fl, present};
        do
            @(posedge clk);
        while (!s_tready);
        sb.add_escaped_chars(b, present, fl);
        if (present || fl)
            items_sent++;
        @(negedge clk);
    endtask

    // one random run: mostly well-formed characters with random content, the rest broken
    // boundaries, truncated sequences, raw noise and flush or empty words
    task automatic send_random_run();
        logic [7:0] run [$];
        logic [7:0] lead;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            run = {run, rand_byte(8'h00, 8'h7F)};
        end
        else if (kind < 45)
        begin
            run = {run, rand_byte(8'hC2, 8'hDF)};
            run = {run, rand_byte(8'h80, 8'hBF)};
        end
        else if (kind < 60)
        begin
            lead = rand_byte(8'hE0, 8'hEF);
            run = {run, lead};
            if (lead == 8'hE0)
                run = {run, rand_byte(8'hA0, 8'hBF)};
            else if (lead == 8'hED)
                run = {run, rand_byte(8'h80, 8'h9F)};
            else
                run = {run, rand_byte(8'h80, 8'hBF)};
            run = {run, rand_byte(8'h80, 8'hBF)};
        end
        else if (kind < 75)
        begin
            lead = rand_byte(8'hF0, 8'hF4);
            run = {run, lead};
            if (lead == 8'hF0)
                run = {run, rand_byte(8'h90, 8'hBF)};
            else if (lead == 8'hF4)
                run = {run, rand_byte(8'h80, 8'h8F)};
            else
                run = {run, rand_byte(8'h80, 8'hBF)};
            run = {run, rand_byte(8'h80, 8'hBF)};
            run = {run, rand_byte(8'h80, 8'hBF)};
        end
        else if (kind < 85)
        begin
            // just past the allowed second-byte range: overlong, surrogate, too large
            case ($urandom_range(0, 3))
                0:
                begin
                    run = {run, 8'hE0};
                    run = {run, rand_byte(8'h80, 8'h9F)};
                end
                1:
                begin
                    run = {run, 8'hED};
                    run = {run, rand_byte(8'hA0, 8'hBF)};
                end
                2:
                begin
                    run = {run, 8'hF0};
                    run = {run, rand_byte(8'h80, 8'h8F)};
                    run = {run, rand_byte(8'h80, 8'hBF)};
                end
                default:
                begin
                    run = {run, 8'hF4};
                    run = {run, rand_byte(8'h90, 8'hBF)};
                    run = {run, rand_byte(8'h80, 8'hBF)};
                end
            endcase
            run = {run, rand_byte(8'h80, 8'hBF)};
        end
        else if (kind < 93)
        begin
            run = {run, rand_byte(8'h00, 8'hFF)};
        end
        else if (kind < 97)
        begin
            // sequence cut short by whatever byte comes next
            lead = rand_byte(8'hC2, 8'hF4);
            run = {run, lead};
            if (lead >= 8'hE0)
                run = {run, rand_byte(8'h80, 8'hBF)};
            run = {run, rand_byte(8'h00, 8'hFF)};
        end
        else
        begin
            // flush-only word, empty word or byte with flush
            case ($urandom_range(0, 2))
                0:       send_word(rand_byte(8'h00, 8'hFF), 1'b0, 1'b1);
                1:       send_word(rand_byte(8'h00, 8'hFF), 1'b0, 1'b0);
                default: send_word(rand_byte(8'h00, 8'hFF), 1'b1, 1'b1);
            endcase
            return;
        end
        foreach (run[i])
            send_word(run[i], 1'b1, $urandom_range(0, 49) == 0);
    endtask

    // receiver: random stall before every word, plus one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_pending)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 1'b0;
            end
            stall = recv_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_char(m_tdata, m_tlast);
            @(negedge clk);
        end
    end

    initial
    begin
        sb = new();
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = 2'b00;
        m_tready     = 1'b0;
        rst_n        = 1'b0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        hold_pending = 1'b0;
        items_sent   = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single bytes: nul, space, del, lf, tab, stray continuation, bad lead
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h20, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h0A, 1'b1, 1'b0);
        send_word(8'h09, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        // two-byte character, U+00BF
        send_word(8'hC2, 1'b1, 1'b0);
        send_word(8'hBF, 1'b1, 1'b0);
        // overlong three-byte form, rejected once complete
        send_word(8'hE0, 1'b1, 1'b0);
        send_word(8'h9F, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        // surrogate prefix held, then escaped by a flush-only word
        send_word(8'hED, 1'b1, 1'b0);
        send_word(8'hA0, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b1);
        // empty word, then flush with nothing held
        send_word(8'hAA, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // lead held although the next byte is no continuation; byte with flush
        send_word(8'hE2, 1'b1, 1'b0);
        send_word(8'h41, 1'b1, 1'b0);
        send_word(8'h82, 1'b1, 1'b1);
        // highest code point, U+10FFFF
        send_word(8'hF4, 1'b1, 1'b0);
        send_word(8'h8F, 1'b1, 1'b0);
        send_word(8'hBF, 1'b1, 1'b0);
        send_word(8'hBF, 1'b1, 1'b0);
        // lead above the four-byte range
        send_word(8'hF5, 1'b1, 1'b0);

        // random runs with idling on both sides
        items_sent = 0;
        while (items_sent < 150)
            send_random_run();

        // a stretch with no idling at all
        send_idle = 1'b0;
        recv_idle = 1'b0;
        while (items_sent < 210)
            send_random_run();

        // receiver holds off while the sender keeps pushing words
        recv_idle    = 1'b1;
        hold_pending = 1'b1;
        while (items_sent < 260)
            send_random_run();

        // flush whatever is still held, then let the output drain
        send_idle = 1'b1;
        send_word(8'h00, 1'b0, 1'b1);
        s_tvalid = 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
